[rtl/mtc_pkg.sv]
// Package for the magnetometer trim compensation block.
// Shared types, queue sizing, divider sizing and special-value codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mtc_pkg;

  localparam int MTC_SENSORS = 8;
  localparam int QDEPTH      = 2;
  localparam int QLW         = $clog2(QDEPTH + 1);
  localparam int QPW         = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  localparam int DIV_NW = 33;
  localparam int DIV_DW = 17;

  localparam logic signed [12:0] AXIS_OVF   = -13'sd4096;
  localparam logic signed [14:0] Z_OVF      = -15'sd16384;
  localparam logic signed [15:0] FAULT_CODE = -16'sd32768;
  localparam logic [15:0]        Z_SAT      = 16'd32767;

  typedef enum logic {
    REQ_COMP = 1'b0,
    REQ_LOAD = 1'b1
  } req_type_t;

  typedef struct packed {
    logic signed [12:0] x;
    logic signed [12:0] y;
    logic signed [14:0] z;
    logic [13:0]        rh;
    logic [63:0]        w0;
    logic [63:0]        w1;
  } mtc_item_t;

  typedef struct packed {
    logic               start;
    logic [DIV_NW-1:0]  num;
    logic [DIV_DW-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic [DIV_NW-1:0]  quo;
  } div_rsp_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_DIVR,
    BK_WAITR,
    BK_M1,
    BK_M2,
    BK_M3,
    BK_M4,
    BK_M5,
    BK_M6,
    BK_WAITZ
  } bk_state_t;

endpackage
`default_nettype wire

[rtl/magnetometer_trim_compensation.sv]
// Top level of the magnetometer trim compensation block.
// Instantiates mtc_front, mtc_queue, mtc_div and mtc_back; uses mtc_pkg.
//
// Usage:
//   Command channel: a word is taken at a rising edge with start high and
//   busy low. in_req_type selects a trim load (in_word_select picks the xy
//   or z word of sensor in_sensor_index) or a sample compensation.
//   Loads write the trim store and produce no result.
//   Result channel: out_valid strobes for one cycle with out_comp_x/y/z;
//   the receiver takes it on that edge and cannot hold it off.
//   Throughput is set by the single serial divider, which runs one 33-step
//   division for the hall ratio and, unless the z divisor is zero, one for
//   the z quotient per sample. The front end keeps taking words into a
//   two-deep queue while the back end computes; busy rises when the words
//   in the queue plus the one in the read stage reach the queue depth.
//   Reset clears control state only; trims read before being loaded are
//   undefined.
`timescale 1ns / 1ps
`default_nettype none
module magnetometer_trim_compensation import mtc_pkg::*; #(
  parameter int SENSORS = MTC_SENSORS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_req_type,
  input  wire logic [2:0]         in_sensor_index,
  input  wire logic               in_word_select,
  input  wire logic [63:0]        in_cal_word,
  input  wire logic signed [15:0] in_raw_x,
  input  wire logic signed [15:0] in_raw_y,
  input  wire logic signed [15:0] in_raw_z,
  input  wire logic [15:0]        in_raw_hall,
  output logic                    out_valid,
  output logic signed [15:0]      out_comp_x,
  output logic signed [15:0]      out_comp_y,
  output logic signed [15:0]      out_comp_z
);

  logic           push, pop, q_empty;
  mtc_item_t      push_item, head;
  logic [QLW-1:0] q_level;
  div_req_t       div_req;
  div_rsp_t       div_rsp;

  mtc_front #(.SENSORS(SENSORS)) u_front (
    .clk, .rst_n, .start, .busy,
    .in_req_type, .in_sensor_index, .in_word_select, .in_cal_word,
    .in_raw_x, .in_raw_y, .in_raw_z, .in_raw_hall,
    .q_level, .push, .push_item
  );

  mtc_queue u_queue (
    .clk, .rst_n, .push, .push_item, .pop, .head,
    .empty(q_empty), .level(q_level)
  );

  mtc_div u_div (
    .clk, .rst_n, .req(div_req), .rsp(div_rsp)
  );

  mtc_back u_back (
    .clk, .rst_n, .head, .q_empty, .pop, .div_req, .div_rsp,
    .out_valid, .out_comp_x, .out_comp_y, .out_comp_z
  );

endmodule
`default_nettype wire

[rtl/mtc_front.sv]
// Front end: accepts commands, holds the trim store, reads trims for samples.
// Pushes prepared sample words into the queue. Depends on mtc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mtc_front import mtc_pkg::*; #(
  parameter int SENSORS = MTC_SENSORS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_req_type,
  input  wire logic [2:0]         in_sensor_index,
  input  wire logic               in_word_select,
  input  wire logic [63:0]        in_cal_word,
  input  wire logic signed [15:0] in_raw_x,
  input  wire logic signed [15:0] in_raw_y,
  input  wire logic signed [15:0] in_raw_z,
  input  wire logic [15:0]        in_raw_hall,
  input  wire logic [QLW-1:0]     q_level,
  output logic                    push,
  output mtc_item_t               push_item
);

  localparam int IW = (SENSORS > 1) ? $clog2(SENSORS) : 1;

  logic [63:0] mem0 [SENSORS];
  logic [63:0] mem1 [SENSORS];

  logic [63:0]        rd0_r, rd1_r;
  logic               rd_valid_r, range_r;
  logic signed [12:0] x_r, y_r;
  logic signed [14:0] z_r;
  logic [13:0]        rh_r;

  logic          accept;
  logic [IW+2:0] idx_wide;
  logic [IW-1:0] addr;
  logic          in_range;

  assign accept   = start && !busy;
  assign idx_wide = {{IW{1'b0}}, in_sensor_index};
  assign addr     = idx_wide[IW-1:0];
  assign in_range = idx_wide < (IW+3)'(SENSORS);

  // leave room for the word still in the read stage
  assign busy = (32'(q_level) + 32'(rd_valid_r)) >= QDEPTH;

  always_ff @(posedge clk) begin
    if (accept && (in_req_type == REQ_LOAD) && in_range) begin
      if (in_word_select) begin
        mem1[addr] <= in_cal_word;
      end else begin
        mem0[addr] <= in_cal_word;
      end
    end
    rd0_r <= mem0[addr];
    rd1_r <= mem1[addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= accept && (in_req_type == REQ_COMP);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      range_r <= in_range;
      x_r     <= 13'(in_raw_x >>> 3);
      y_r     <= 13'(in_raw_y >>> 3);
      z_r     <= 15'(in_raw_z >>> 1);
      rh_r    <= in_raw_hall[15:2];
    end
  end

  assign push         = rd_valid_r;
  assign push_item.x  = x_r;
  assign push_item.y  = y_r;
  assign push_item.z  = z_r;
  assign push_item.rh = rh_r;
  assign push_item.w0 = range_r ? rd0_r : 64'd0;
  assign push_item.w1 = range_r ? rd1_r : 64'd0;

endmodule
`default_nettype wire

[rtl/mtc_queue.sv]
// Short FIFO between the front end and the compute back end.
// Depends on mtc_pkg for the word type and depth.
`timescale 1ns / 1ps
`default_nettype none
module mtc_queue import mtc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire mtc_item_t  push_item,
  input  wire logic       pop,
  output mtc_item_t       head,
  output logic            empty,
  output logic [QLW-1:0]  level
);

  mtc_item_t        slots [QDEPTH];
  logic [QPW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QLW-1:0]   level_r;

  function automatic logic [QPW-1:0] ptr_inc(input logic [QPW-1:0] p);
    return (p == QPW'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head  = slots[rd_ptr_r];
  assign empty = (level_r == '0);
  assign level = level_r;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        level_r <= level_r + 1'b1;
      end else if (pop && !push) begin
        level_r <= level_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/mtc_div.sv]
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on mtc_pkg for request and response types.
`timescale 1ns / 1ps
`default_nettype none
module mtc_div import mtc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam int CW = $clog2(DIV_NW + 1);

  logic              busy_r;
  logic [CW-1:0]     cnt_r;
  logic [DIV_DW-1:0] rem_r, den_r;
  logic [DIV_NW-1:0] quo_r;

  logic [DIV_DW:0] shifted, diff;
  logic            ge;

  assign shifted = {rem_r, quo_r[DIV_NW-1]};
  assign diff    = shifted - {1'b0, den_r};
  assign ge      = !diff[DIV_DW];

  assign rsp.busy = busy_r;
  assign rsp.quo  = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(DIV_NW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.num;
      den_r <= req.den;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DIV_DW-1:0] : shifted[DIV_DW-1:0];
      quo_r <= {quo_r[DIV_NW-2:0], ge};
    end
  end

endmodule
`default_nettype wire

[rtl/mtc_back.sv]
// Back end: sequences the x/y/z compensation math for one queued sample.
// Uses the shared serial divider; depends on mtc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mtc_back import mtc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire mtc_item_t   head,
  input  wire logic        q_empty,
  output logic             pop,
  output div_req_t         div_req,
  input  wire div_rsp_t    div_rsp,
  output logic             out_valid,
  output logic signed [15:0] out_comp_x,
  output logic signed [15:0] out_comp_y,
  output logic signed [15:0] out_comp_z
);

  bk_state_t state_r, state_nxt;
  mtc_item_t it_r;

  logic signed [31:0] t1p_r;
  logic [30:0]        t3_r;
  logic signed [15:0] r_r;
  logic signed [16:0] zden_r;
  logic signed [32:0] znum_r;
  logic [31:0]        rr_r;
  logic signed [24:0] t6_r;
  logic signed [33:0] t4_r;
  logic signed [27:0] t7_r;
  logic signed [37:0] px_r, py_r;
  logic signed [39:0] qpx_r, qpy_r;
  logic signed [15:0] cx_r, cy_r, cz_r;
  logic               out_valid_r;

  // trim fields
  logic [15:0]        xyz1, z1;
  logic [7:0]         xy1;
  logic signed [7:0]  xy2, a1x, a1y, a2x, a2y;
  logic signed [15:0] z2, z3, z4;
  logic               bad_hall;

  assign a1x  = it_r.w0[7:0];
  assign a1y  = it_r.w0[15:8];
  assign a2x  = it_r.w0[23:16];
  assign a2y  = it_r.w0[31:24];
  assign xy1  = it_r.w0[39:32];
  assign xy2  = it_r.w0[47:40];
  assign xyz1 = it_r.w0[63:48];
  assign z1   = it_r.w1[15:0];
  assign z2   = it_r.w1[31:16];
  assign z3   = it_r.w1[47:32];
  assign z4   = it_r.w1[63:48];
  assign bad_hall = (it_r.rh == 14'd0);

  // z numerator and divisor terms
  logic signed [15:0] t0;
  logic signed [16:0] dz;
  logic signed [31:0] t2, t1;
  logic [31:0]        t3s;
  logic signed [15:0] t4z;
  logic signed [16:0] zden;
  logic signed [32:0] znum;

  assign t0   = {2'b00, it_r.rh} - xyz1;
  assign dz   = {{2{it_r.z[14]}}, it_r.z} - {z4[15], z4};
  assign t2   = {dz, 15'd0};
  assign t1   = (t1p_r + (t1p_r[31] ? 32'sd3 : 32'sd0)) >>> 2;
  assign t3s  = {1'b0, t3_r} + 32'd32768;
  assign t4z  = t3s[31:16];
  assign zden = {z2[15], z2} + {t4z[15], t4z};
  assign znum = {t2[31], t2} - {t1[31], t1};

  // xy terms
  logic signed [31:0] rr_p;
  logic signed [34:0] sum9, adj9;
  logic signed [25:0] t7_base;
  logic signed [9:0]  ax2, ay2;
  logic signed [37:0] adjx12, adjy12;
  logic signed [26:0] t9x, t9y;
  logic signed [39:0] adjx13, adjy13;
  logic signed [15:0] qx, qy;

  assign rr_p    = r_r * r_r;
  assign sum9    = {t4_r[33], t4_r} + {{3{t6_r[24]}}, t6_r, 7'd0};
  assign adj9    = sum9 + (sum9[34] ? 35'sd511 : 35'sd0);
  assign t7_base = adj9[34:9];
  assign ax2     = {{2{a2x[7]}}, a2x} + 10'sd160;
  assign ay2     = {{2{a2y[7]}}, a2y} + 10'sd160;
  assign adjx12  = px_r + (px_r[37] ? 38'sd4095 : 38'sd0);
  assign adjy12  = py_r + (py_r[37] ? 38'sd4095 : 38'sd0);
  assign t9x     = 27'(adjx12 >>> 12);
  assign t9y     = 27'(adjy12 >>> 12);
  assign adjx13  = qpx_r + (qpx_r[39] ? 40'sd8191 : 40'sd0);
  assign adjy13  = qpy_r + (qpy_r[39] ? 40'sd8191 : 40'sd0);
  assign qx      = adjx13[28:13];
  assign qy      = adjy13[28:13];

  // z quotient sign and saturation
  logic               zneg;
  logic [15:0]        zmag;
  logic signed [15:0] cz_val;

  assign zneg   = znum_r[32] ^ zden_r[16];
  assign zmag   = (div_rsp.quo > DIV_NW'(Z_SAT)) ? Z_SAT : div_rsp.quo[15:0];
  assign cz_val = zneg ? -zmag : zmag;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE:  if (!q_empty) state_nxt = BK_DIVR;
      BK_DIVR:  state_nxt = BK_WAITR;
      BK_WAITR: if (!div_rsp.busy) state_nxt = BK_M1;
      BK_M1:    state_nxt = BK_M2;
      BK_M2:    state_nxt = BK_M3;
      BK_M3:    state_nxt = BK_M4;
      BK_M4:    state_nxt = BK_M5;
      BK_M5:    state_nxt = BK_M6;
      BK_M6:    state_nxt = BK_WAITZ;
      BK_WAITZ: if (!div_rsp.busy) state_nxt = BK_IDLE;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop           = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = {3'd0, xyz1, 14'd0};
    div_req.den   = {3'd0, it_r.rh};
    case (state_r)
      BK_IDLE: pop = !q_empty;
      BK_DIVR: div_req.start = 1'b1;
      BK_M1: begin
        div_req.start = (zden_r != 17'sd0);
        div_req.num   = znum_r[32] ? 33'(-znum_r) : 33'(znum_r);
        div_req.den   = zden_r[16] ? 17'(-zden_r) : 17'(zden_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == BK_WAITZ) && !div_rsp.busy;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: if (!q_empty) it_r <= head;
      BK_DIVR: begin
        t1p_r <= z3 * t0;
        t3_r  <= z1 * {it_r.rh, 1'b0};
      end
      BK_WAITR: begin
        r_r    <= div_rsp.quo[15:0] - 16'h4000;
        zden_r <= zden;
        znum_r <= znum;
      end
      BK_M1: begin
        rr_r <= rr_p;
        t6_r <= r_r * $signed({1'b0, xy1});
      end
      BK_M2: t4_r <= xy2 * $signed({1'b0, rr_r[31:7]});
      BK_M3: t7_r <= {{2{t7_base[25]}}, t7_base} + 28'sh0100000;
      BK_M4: begin
        px_r <= t7_r * ax2;
        py_r <= t7_r * ay2;
      end
      BK_M5: begin
        qpx_r <= it_r.x * t9x;
        qpy_r <= it_r.y * t9y;
      end
      BK_M6: begin
        cx_r <= (bad_hall || it_r.x == AXIS_OVF) ? FAULT_CODE :
                qx + {{5{a1x[7]}}, a1x, 3'd0};
        cy_r <= (bad_hall || it_r.y == AXIS_OVF) ? FAULT_CODE :
                qy + {{5{a1y[7]}}, a1y, 3'd0};
      end
      BK_WAITZ: begin
        if (!div_rsp.busy) begin
          cz_r <= (bad_hall || it_r.z == Z_OVF || zden_r == 17'sd0) ? FAULT_CODE
                                                                      : cz_val;
        end
      end
      default: ;
    endcase
  end

  assign out_valid  = out_valid_r;
  assign out_comp_x = cx_r;
  assign out_comp_y = cy_r;
  assign out_comp_z = cz_r;

endmodule
`default_nettype wire

[rtl/mtc_checker.sv]
// Port-level checks for magnetometer_trim_compensation, bound to the top.
// Depends on the top level's port list only.
`timescale 1ns / 1ps
`default_nettype none
module mtc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        in_req_type,
  input wire logic [2:0]  in_sensor_index,
  input wire logic        in_word_select,
  input wire logic [63:0] in_cal_word,
  input wire logic [15:0] in_raw_x,
  input wire logic [15:0] in_raw_y,
  input wire logic [15:0] in_raw_z,
  input wire logic [15:0] in_raw_hall,
  input wire logic        out_valid,
  input wire logic [15:0] out_comp_x,
  input wire logic [15:0] out_comp_y,
  input wire logic [15:0] out_comp_z
);

  // result strobes never come back to back
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held two cycles");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> !busy)
    else $error("busy right after reset");

  // no result strobe just after reset is released
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |=> !out_valid)
    else $error("result too soon after reset");

endmodule

bind magnetometer_trim_compensation mtc_checker u_mtc_checker (.*);
`default_nettype wire
